// ===== src/view_stride_solver_core_defines.svh =====
// Assertion macros for the view stride solver checker.
// Included by files that hold concurrent assertions.
`ifndef VIEW_STRIDE_SOLVER_CORE_DEFINES_SVH
`define VIEW_STRIDE_SOLVER_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define VSS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: check failed");
// next-cycle implication
`define VSS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: check failed");
`endif

// ===== src/vss_pkg.sv =====
// Shared types and constants for the view stride solver.
// No dependencies.
`default_nettype none
package vss_pkg;
  localparam int MaxDimsDefault = 8;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_LOAD_OLD = 2'd0,
    CMD_LOAD_NEW = 2'd1,
    CMD_SOLVE    = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] dim_size;
    logic [47:0] dim_stride;
  } in_item_t;

  typedef struct packed {
    logic [47:0] new_stride;
    logic [2:0]  dim_index;
    logic        has_stride;
    logic        ok;
    logic        last;
  } out_item_t;

  localparam logic [63:0] Limit63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Mask48  = 64'h0000_FFFF_FFFF_FFFF;
endpackage
`default_nettype wire

// ===== src/vss_front.sv =====
// Front end: accepts command transactions, drops no-ops, queues the rest.
// Depends on vss_pkg.
`default_nettype none
module vss_front import vss_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_item_t item,
  output logic          busy,
  output in_item_t      q_item,
  output logic          q_valid,
  input  wire logic     q_pop
);
  in_item_t     q [QueueDepth];
  logic         wp, rp;
  logic [1:0]   cnt;
  logic         push;

  assign busy    = (cnt == 2'(QueueDepth));
  assign push    = start && !busy && (item.command != CMD_NOP);
  assign q_valid = (cnt != 2'd0);
  assign q_item  = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= item;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ===== src/vss_back.sv =====
// Back end: stores shapes and runs the stride solve as a sequencer
// around one shared overflow-checked 64x32 multiply built from two 32x32
// halves. Depends on vss_pkg.
`default_nettype none
module vss_back import vss_pkg::*; #(
  parameter int MAX_DIMS = MaxDimsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  q_item,
  input  wire logic      q_valid,
  output logic           q_pop,
  output out_item_t      result,
  output logic           strobe
);
  localparam int IW = $clog2(MAX_DIMS) < 1 ? 1 : $clog2(MAX_DIMS);
  localparam int RW = $clog2(MAX_DIMS + 1);
  localparam logic signed [RW:0] IOne = (RW+1)'(1);
  localparam logic signed [RW:0] ITwo = (RW+1)'(2);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_NUMEL = 12'b000000000010,
    S_EMPTY = 12'b000000000100,
    S_MAIN  = 12'b000000001000,
    S_OSKIP = 12'b000000010000,
    S_GROW  = 12'b000000100000,
    S_EMIT  = 12'b000001000000,
    S_TAIL  = 12'b000010000000,
    S_OUT   = 12'b000100000000,
    S_FAIL  = 12'b001000000000,
    S_MWAIT = 12'b010000000000,
    S_CHECK = 12'b100000000000
  } state_t;

  logic [31:0] old_sizes   [MAX_DIMS];
  logic [47:0] old_strides [MAX_DIMS];
  logic [31:0] new_sizes   [MAX_DIMS];
  logic [47:0] solved      [MAX_DIMS];
  logic [RW-1:0] old_rank, new_rank;
  logic          load_overflow;

  state_t state, ret;
  // signed walk indexes, -1 means exhausted
  logic signed [RW:0] oi, ni, top, k;
  logic [IW-1:0] prev;
  logic [63:0] acc, nc, oc, strd;
  logic        grow_new;
  logic [RW-1:0] oidx;

  // shared multiplier: operands registered, two 32x32 halves, then the sum
  logic [63:0]  ma;
  logic [31:0]  mb;
  logic [63:0]  plo, phi;
  logic [95:0]  mp;
  logic [1:0]   mph;

  wire [IW-1:0] oiw = oi[IW-1:0];
  wire [IW-1:0] niw = ni[IW-1:0];
  wire [IW-1:0] kw  = k[IW-1:0];
  wire [IW-1:0] oiv = oidx[IW-1:0];
  wire          mov = (mp[95:63] != '0);

  assign q_pop = q_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    plo <= ma[31:0] * mb;
    phi <= ma[63:32] * mb;
    mp  <= {phi, 32'd0} + {32'd0, plo};
    if (rst) begin
      state <= S_IDLE; old_rank <= '0; new_rank <= '0; load_overflow <= 1'b0;
      strobe <= 1'b0; mph <= 2'd0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: if (q_valid) begin
          case (q_item.command)
            CMD_LOAD_OLD:
              if (old_rank < RW'(MAX_DIMS)) begin
                old_sizes[old_rank[IW-1:0]]   <= q_item.dim_size;
                old_strides[old_rank[IW-1:0]] <= q_item.dim_stride;
                old_rank <= old_rank + 1'b1;
              end else load_overflow <= 1'b1;
            CMD_LOAD_NEW:
              if (new_rank < RW'(MAX_DIMS)) begin
                new_sizes[new_rank[IW-1:0]] <= q_item.dim_size;
                new_rank <= new_rank + 1'b1;
              end else load_overflow <= 1'b1;
            CMD_SOLVE: begin
              if (load_overflow) state <= S_FAIL;
              else begin
                acc <= 64'd1; k <= '0; state <= S_NUMEL;
              end
            end
            default: ;
          endcase
        end
        S_NUMEL: begin
          if (k[RW-1:0] == old_rank) begin
            if (acc == 64'd0) begin
              if (new_rank == '0) state <= S_FAIL;
              else begin
                k <= {1'b0, new_rank} - ITwo;
                solved[new_rank[IW-1:0] - 1'b1] <= 48'd1;
                acc <= 64'd1;
                state <= S_EMPTY;
              end
            end else begin
              oi <= {1'b0, old_rank} - IOne; ni <= {1'b0, new_rank} - IOne;
              state <= S_MAIN;
            end
          end else begin
            ma <= acc; mb <= old_sizes[kw];
            ret <= S_NUMEL; state <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (mph != 2'd2) mph <= mph + 2'd1;
          else begin
            mph <= 2'd0;
            if (ret == S_CHECK) begin
              // merged old dim must sit at size*stride of the previous one
              if (mp != {48'd0, old_strides[oiw]}) state <= S_FAIL;
              else begin
                prev <= oiw; grow_new <= 1'b0;
                ma <= oc; mb <= old_sizes[oiw];
                ret <= S_GROW;
              end
            end else if (mov) state <= S_FAIL;
            else begin
              state <= ret;
              case (ret)
                S_NUMEL: begin acc <= mp[63:0]; k <= k + IOne; end
                S_EMPTY: begin
                  if (mp[63:48] != '0) state <= S_FAIL;
                  else begin
                    solved[kw] <= mp[47:0]; acc <= mp[63:0]; k <= k - IOne;
                  end
                end
                S_GROW: begin
                  if (grow_new) nc <= mp[63:0]; else oc <= mp[63:0];
                end
                S_EMIT: begin strd <= mp[63:0]; k <= k + IOne; end
                default: ;
              endcase
            end
          end
        end
        S_EMPTY: begin
          if (k < 0) state <= S_OUT;
          else begin
            ma <= acc; mb <= new_sizes[IW'(k + IOne)];
            ret <= S_EMPTY; state <= S_MWAIT;
          end
        end
        S_MAIN: begin
          if (oi < 0 || ni < 0) state <= S_TAIL;
          else if (new_sizes[niw] == 32'd1) begin
            solved[niw] <= 48'd0; ni <= ni - IOne;
          end else if (old_sizes[oiw] == 32'd1) begin
            // old dims ran out under a new dim that is not size 1
            if (oi == 0) state <= S_FAIL;
            else oi <= oi - IOne;
          end else if (new_sizes[niw] == old_sizes[oiw]) begin
            solved[niw] <= old_strides[oiw]; ni <= ni - IOne; oi <= oi - IOne;
          end else begin
            nc <= {32'd0, new_sizes[niw]}; oc <= {32'd0, old_sizes[oiw]};
            strd <= {16'd0, old_strides[oiw]};
            top <= ni; prev <= oiw; state <= S_GROW;
          end
        end
        S_GROW: begin
          if (nc == oc) begin k <= ni; state <= S_EMIT; end
          else if (nc < oc) begin
            if (ni == 0) state <= S_FAIL;
            else begin
              ni <= ni - IOne; grow_new <= 1'b1;
              ma <= nc; mb <= new_sizes[IW'(ni - IOne)];
              ret <= S_GROW; state <= S_MWAIT;
            end
          end else begin
            oi <= oi - IOne; state <= S_OSKIP;
          end
        end
        S_OSKIP: begin
          if (oi < 0) state <= S_FAIL;
          else if (old_sizes[oiw] == 32'd1) oi <= oi - IOne;
          else begin
            ma <= {16'd0, old_strides[prev]}; mb <= old_sizes[prev];
            ret <= S_CHECK; state <= S_MWAIT;
          end
        end
        S_EMIT: begin
          if (k > top) begin ni <= ni - IOne; oi <= oi - IOne; state <= S_MAIN; end
          else if (strd[63:48] != '0) state <= S_FAIL;
          else begin
            solved[kw] <= strd[47:0];
            ma <= strd; mb <= new_sizes[kw];
            ret <= S_EMIT; state <= S_MWAIT;
          end
        end
        S_TAIL: begin
          if (ni >= 0) begin solved[niw] <= 48'd0; ni <= ni - IOne; end
          else if (oi >= 0 && old_sizes[oiw] == 32'd1) oi <= oi - IOne;
          else if (oi >= 0) state <= S_FAIL;
          else begin oidx <= '0; state <= S_OUT; end
        end
        S_OUT: begin
          strobe <= 1'b1;
          result.ok <= 1'b1;
          if (new_rank == '0) begin
            result.new_stride <= '0; result.dim_index <= '0;
            result.has_stride <= 1'b0; result.last <= 1'b1;
          end else begin
            result.new_stride <= solved[oiv];
            result.dim_index  <= 3'(oidx);
            result.has_stride <= 1'b1;
            result.last       <= (oidx + 1'b1 == new_rank);
          end
          if (new_rank == '0 || oidx + 1'b1 == new_rank) begin
            state <= S_IDLE; old_rank <= '0; new_rank <= '0; load_overflow <= 1'b0;
          end
          oidx <= oidx + 1'b1;
        end
        S_FAIL: begin
          strobe <= 1'b1;
          result <= '{new_stride: '0, dim_index: '0, has_stride: 1'b0,
                      ok: 1'b0, last: 1'b1};
          state <= S_IDLE; old_rank <= '0; new_rank <= '0; load_overflow <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_EMPTY && k < 0) oidx <= '0;
    end
  end
endmodule
`default_nettype wire

// ===== src/view_stride_solver_core.sv =====
// View stride solver: a two-entry queue feeds the back end, which takes loads
// back to back. A solve runs the element count over the old dims, then walks
// matched, size-1 and merged dims, each product going through the shared
// multiplier. Results then follow one per cycle and cannot be stalled; later
// transactions wait in the queue.
// Reset clears ranks, overflow flag, queue and sequencer; shape stores stay.
`default_nettype none
module view_stride_solver_core import vss_pkg::*; #(
  parameter int MAX_DIMS = MaxDimsDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire in_item_t item,
  output logic          busy,
  output out_item_t     result,
  output logic          strobe
);
  in_item_t q_item;
  logic     q_valid, q_pop;

  vss_front u_front (
    .clk, .rst, .start, .item, .busy, .q_item, .q_valid, .q_pop
  );
  vss_back #(.MAX_DIMS(MAX_DIMS)) u_back (
    .clk, .rst, .q_item, .q_valid, .q_pop, .result, .strobe
  );
endmodule
`default_nettype wire

// ===== src/vss_checker.sv =====
// Port-level checker for view_stride_solver_core, bound to the top level.
// Depends on vss_pkg and the defines header.
`default_nettype none
`include "view_stride_solver_core_defines.svh"
module vss_sva import vss_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire out_item_t result,
  input wire logic      strobe
);
  `VSS_ASSERT_IMP(a_fail_last, clk, rst, strobe && !result.ok, result.last)
  `VSS_ASSERT_IMP(a_fail_nostride, clk, rst, strobe && !result.has_stride, result.last)
  `VSS_ASSERT_NXT(a_index_seq, clk, rst, strobe && !result.last, strobe && result.dim_index == $past(result.dim_index) + 3'd1)
endmodule
bind view_stride_solver_core vss_sva u_vss_sva (
  .clk, .rst, .result, .strobe
);
`default_nettype wire

// ===== tb/sv/vss_checker.sv =====
// Checker for the view stride solver: watches accepted commands, predicts the
// stride results and compares them with the strobed results. Uses vss_pkg.
`default_nettype none
module vss_checker import vss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_item_t  item,
  input  wire logic      strobe,
  input  wire out_item_t result,
  output int             errors,
  output int             pending
);
  localparam int Dims = MaxDimsDefault;
  localparam logic [63:0] Lim63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Msk48 = 64'h0000_FFFF_FFFF_FFFF;

  logic [31:0] osz [Dims];
  logic [63:0] ost [Dims];
  logic [31:0] nsz [Dims];
  logic [63:0] sol [Dims];
  int orank, nrank;
  bit  ovf;
  out_item_t strides_due[$];

  assign pending = strides_due.size();

  // product capped at 2^63-1; returns 1 on overflow
  function automatic bit mul_ovf(input logic [63:0] a, input logic [63:0] b,
                                 output logic [63:0] r);
    r = 0;
    if (a != 0 && b > Lim63 / a) return 1;
    r = a * b;
    return 0;
  endfunction

  function automatic bit merge_ok(input int prv, input int cur);
    logic [63:0] s, z;
    s = ost[prv];
    z = {32'd0, osz[prv]};
    if (s != 0 && z > Msk48 / s) return 0;
    return ost[cur] == z * s;
  endfunction

  function automatic bit view_strides();
    logic [63:0] numel, nc, oc, stride;
    int oi, ni, top, prv;
    numel = 1;
    for (int i = 0; i < orank; i++)
      if (mul_ovf(numel, {32'd0, osz[i]}, numel)) return 0;
    if (numel == 0) begin
      if (nrank == 0) return 0;
      sol[nrank-1] = 1;
      for (int i = nrank - 2; i >= 0; i--) begin
        if (mul_ovf(sol[i+1], {32'd0, nsz[i+1]}, sol[i])) return 0;
        if (sol[i] > Msk48) return 0;
      end
      return 1;
    end
    oi = orank - 1;
    ni = nrank - 1;
    while (oi >= 0 && ni >= 0) begin
      if (nsz[ni] == 1) begin
        sol[ni] = 0;
        ni--;
        continue;
      end
      while (oi >= 0 && osz[oi] == 1) oi--;
      if (oi < 0) return 0;
      if (nsz[ni] == osz[oi]) begin
        sol[ni] = ost[oi];
        ni--;
        oi--;
        continue;
      end
      nc = {32'd0, nsz[ni]};
      oc = {32'd0, osz[oi]};
      stride = ost[oi];
      top = ni;
      prv = oi;
      while (nc != oc) begin
        if (nc < oc) begin
          ni--;
          if (ni < 0) return 0;
          if (mul_ovf(nc, {32'd0, nsz[ni]}, nc)) return 0;
        end else begin
          oi--;
          while (oi >= 0 && osz[oi] == 1) oi--;
          if (oi < 0) return 0;
          if (!merge_ok(prv, oi)) return 0;
          if (mul_ovf(oc, {32'd0, osz[oi]}, oc)) return 0;
          prv = oi;
        end
      end
      for (int k = ni; k <= top; k++) begin
        if (stride > Msk48) return 0;
        sol[k] = stride;
        if (mul_ovf(stride, {32'd0, nsz[k]}, stride)) return 0;
      end
      ni--;
      oi--;
    end
    while (ni >= 0) begin
      sol[ni] = 0;
      ni--;
    end
    while (oi >= 0 && osz[oi] == 1) oi--;
    return oi < 0;
  endfunction

  task automatic apply_command(input in_item_t it);
    out_item_t r;
    bit good;
    case (cmd_t'(it.command))
      CMD_LOAD_OLD: begin
        if (orank < Dims) begin
          osz[orank] = it.dim_size;
          ost[orank] = {16'd0, it.dim_stride};
          orank++;
        end else ovf = 1;
      end
      CMD_LOAD_NEW: begin
        if (nrank < Dims) begin
          nsz[nrank] = it.dim_size;
          nrank++;
        end else ovf = 1;
      end
      CMD_SOLVE: begin
        good = !ovf && view_strides();
        if (good && nrank > 0) begin
          for (int k = 0; k < nrank; k++) begin
            r.new_stride = sol[k][47:0];
            r.dim_index = 3'(k);
            r.has_stride = 1;
            r.ok = 1;
            r.last = (k + 1 == nrank);
            strides_due.push_back(r);
          end
        end else begin
          r = '0;
          r.ok = good;
          r.last = 1;
          strides_due.push_back(r);
        end
        orank = 0;
        nrank = 0;
        ovf = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      orank = 0;
      nrank = 0;
      ovf = 0;
      strides_due.delete();
      errors <= 0;
    end else begin
      // results first: a solve accepted now cannot produce a result this edge
      if (strobe) begin
        if (strides_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, result);
          errors <= errors + 1;
        end else begin
          if (strides_due[0] !== result) begin
            $display("%0t: mismatch expected %h actual %h (stride/idx/has/ok/last)",
                     $time, strides_due[0], result);
            errors <= errors + 1;
          end
          void'(strides_due.pop_front());
        end
      end
      if (start && !busy) apply_command(item);
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Top of the view stride solver testbench: clock, reset, command stimulus
// and verdict. Depends on vss_pkg, view_stride_solver_core and vss_checker.
`default_nettype none
module tb_top import vss_pkg::*;;
  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  in_item_t item = '0;
  logic busy, strobe;
  out_item_t result;
  int errors, pending;
  int cycles = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  view_stride_solver_core dut (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .result(result), .strobe(strobe)
  );

  vss_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .strobe(strobe), .result(result), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one transaction; random idle cycles ahead of it, start stays up after it
  task automatic send_cmd(input cmd_t c, input logic [31:0] sz, input logic [47:0] st);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    item <= '{command: c, dim_size: sz, dim_stride: st};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_size();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return 0;
      3, 4: return 1;
      default: return $urandom_range(2, 6);
    endcase
  endfunction

  // random mostly contiguous view, new shape from a regrouping of the element count
  task automatic shaped_case();
    logic [31:0] osz [8];
    logic [47:0] st;
    int orn, nrn;
    logic [31:0] f;
    logic [63:0] rem;
    orn = $urandom_range(0, 5);
    rem = 1;
    for (int i = 0; i < orn; i++) begin
      osz[i] = $urandom_range(1, 6);
      if ($urandom_range(19) == 0) osz[i] = 0;
    end
    st = 48'($urandom_range(1, 3));
    if ($urandom_range(9) == 0) st = 48'($urandom);
    for (int i = 0; i < orn; i++) rem *= osz[i];
    // old dims sent outermost first with strides computed innermost out
    begin
      logic [47:0] sarr [8];
      logic [47:0] s;
      s = st;
      for (int i = orn - 1; i >= 0; i--) begin
        sarr[i] = s;
        s = s * (osz[i] == 0 ? 1 : osz[i]);
      end
      if (orn > 0 && $urandom_range(4) == 0) sarr[$urandom_range(orn - 1)] ^= 48'h1;
      for (int i = 0; i < orn; i++) send_cmd(CMD_LOAD_OLD, osz[i], sarr[i]);
    end
    nrn = $urandom_range(0, 6);
    for (int i = 0; i < nrn; i++) begin
      if (i == nrn - 1) f = rem[31:0];
      else if (rem > 1 && rem % 2 == 0 && $urandom_range(1)) f = 2;
      else if (rem % 3 == 0 && $urandom_range(1)) f = 3;
      else f = 1;
      if (f > 1) rem = rem / f;
      send_cmd(CMD_LOAD_NEW, f, 48'($urandom));
    end
    if ($urandom_range(9) == 0) send_cmd(CMD_NOP, $urandom, 48'($urandom));
    send_cmd(CMD_SOLVE, $urandom, 48'({$urandom, $urandom}));
  endtask

  task automatic noise_case();
    int n;
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++)
      send_cmd(cmd_t'($urandom_range(0, 3)), rnd_size(), 48'({$urandom, $urandom}));
    send_cmd(CMD_SOLVE, $urandom, 48'({$urandom, $urandom}));
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty solve, extremes, size-1, merge, split, zero elements, bad merge, rank overflow
    send_cmd(CMD_SOLVE, 0, 0);
    send_cmd(CMD_LOAD_OLD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_cmd(CMD_LOAD_NEW, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_cmd(CMD_SOLVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_cmd(CMD_LOAD_OLD, 2, 3);
    send_cmd(CMD_LOAD_OLD, 3, 1);
    send_cmd(CMD_LOAD_NEW, 6, 0);
    send_cmd(CMD_LOAD_NEW, 1, 0);
    send_cmd(CMD_SOLVE, 0, 0);
    send_cmd(CMD_LOAD_OLD, 6, 1);
    send_cmd(CMD_LOAD_NEW, 2, 0);
    send_cmd(CMD_LOAD_NEW, 3, 0);
    send_cmd(CMD_NOP, 5, 5);
    send_cmd(CMD_SOLVE, 0, 0);
    send_cmd(CMD_LOAD_OLD, 0, 4);
    send_cmd(CMD_SOLVE, 0, 0);
    send_cmd(CMD_LOAD_OLD, 2, 1);
    send_cmd(CMD_LOAD_OLD, 2, 1);
    send_cmd(CMD_LOAD_NEW, 4, 0);
    send_cmd(CMD_SOLVE, 0, 0);
    for (int i = 0; i < 9; i++) send_cmd(CMD_LOAD_NEW, 1, 0);
    send_cmd(CMD_SOLVE, 0, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 68 : (ph == 2 ? 23 : 0);
      for (int j = 0; j < 5; j++) begin
        if ($urandom_range(4) == 0) noise_case();
        else shaped_case();
      end
      if (ph == 2) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+src
src/vss_pkg.sv
src/vss_front.sv
src/vss_back.sv
src/view_stride_solver_core.sv
src/vss_checker.sv
tb/sv/vss_checker.sv
tb/sv/tb_top.sv
